>>> rtl/core/rgbgray_pkg.sv
// ----------------------------------------------------------------------------
// rgbgray_pkg
// shared types, constants and the gamma table function for the gray converter
// ----------------------------------------------------------------------------
package rgbgray_pkg;

  // method codes of the mode register
  typedef enum logic [2:0] {
    METH_MEAN     = 3'd0,
    METH_WEIGHTED = 3'd1,
    METH_SRGB     = 3'd2,
    METH_RED      = 3'd3,
    METH_GREEN    = 3'd4,
    METH_BLUE     = 3'd5,
    METH_SAT      = 3'd6,
    METH_VALUE    = 3'd7
  } gray_mode_t;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned CH_W          = 8;
  localparam int unsigned G_W           = 27;   // 255*255*2048 < 2^27
  localparam int unsigned STEPS         = 8;    // one result bit per step
  localparam int unsigned MEAN_MUL      = 43691; // ceil(2^17/3)
  localparam int unsigned MEAN_SHIFT    = 17;

  // linear-light table entry: i*i*floor(2048*(i/255)^0.2)
  function automatic logic [G_W-1:0] gamma_g(input int unsigned i);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] p;
    logic [63:0] bound;
    logic [63:0] ii;
    ii    = 64'(i);
    lo    = 64'd0;
    hi    = 64'd2048;
    bound = ii << 55;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      p   = mid * mid * mid * mid * mid;
      if (p * 64'd255 <= bound) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return G_W'(ii * ii * lo);
  endfunction

endpackage

>>> rtl/core/rgb_to_gray_multi_method.sv
// ----------------------------------------------------------------------------
// rgb_to_gray_multi_method
// pixel stream to gray level converter with eight selectable methods
// ----------------------------------------------------------------------------
// Takes one RGB pixel per transaction (red in tdata[7:0]) and returns one
// gray byte per pixel, with a new pixel accepted in every clock unless the
// output stalls. The pipeline is 13 register stages deep: four front stages
// (capture, table lookup and min/max, weight multiply, sum and scaling),
// eight step stages that each settle one bit of the sRGB inverse-gamma search
// and one quotient bit of the saturation divider, and the output register.
// While a result waits on out_tready the whole pipeline holds and in_tready
// is low. The mode register (reset: sRGB) is sampled with each pixel at its
// entry.
module rgb_to_gray_multi_method #(
  parameter int unsigned FRAC_BITS = rgbgray_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // gray [7:0]
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rgbgray_pkg::*;

  localparam logic [63:0] W_RED   = ((64'd2126 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic [63:0] W_GREEN = ((64'd7152 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic [63:0] W_BLUE  = ((64'd722 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic [63:0] W_SUM   = W_RED + W_GREEN + W_BLUE;
  localparam int unsigned WW  = FRAC_BITS;          // weight width
  localparam int unsigned YW  = FRAC_BITS + G_W + 1; // weighted linear sum
  localparam int unsigned PW  = WW + CH_W;          // weighted product
  localparam int unsigned SW  = PW + 2;             // weighted sum
  localparam int unsigned MW  = CH_W + 2 + MEAN_SHIFT;

  localparam logic [WW-1:0] WR = WW'(W_RED);
  localparam logic [WW-1:0] WG = WW'(W_GREEN);
  localparam logic [WW-1:0] WB = WW'(W_BLUE);

  // constant tables
  logic [G_W-1:0] g_tab  [256];
  logic [YW-1:0]  gw_tab [256];
  for (genvar i = 0; i < 256; i++) begin : g_gtab
    localparam logic [G_W-1:0] GV = gamma_g(i);
    assign g_tab[i]  = GV;
    assign gw_tab[i] = YW'(64'(GV) * W_SUM);
  end

  // mode register
  gray_mode_t method_r;
  logic       cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & ~cfg_paddr[2];
  assign cfg_prdata = {29'd0, method_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= METH_SRGB;
    end else if (cfg_wr) begin
      method_r <= gray_mode_t'(cfg_pwdata[2:0]);
    end
  end

  // pipeline advance
  logic en;
  logic out_vld_r;
  logic [3:0] fvld_r;
  logic [STEPS-1:0] svld_r;
  assign en        = ~out_vld_r | out_tready;
  assign in_tready = en & rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvld_r    <= '0;
      svld_r    <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      fvld_r    <= {fvld_r[2:0], in_tvalid};
      svld_r    <= {svld_r[STEPS-2:0], fvld_r[3]};
      out_vld_r <= svld_r[STEPS-1];
    end
  end

  // stage 0: capture
  logic [CH_W-1:0] r0_r, g0_r, b0_r;
  gray_mode_t m0_r;
  always_ff @(posedge clk) begin
    if (en) begin
      r0_r <= in_tdata[7:0];
      g0_r <= in_tdata[15:8];
      b0_r <= in_tdata[23:16];
      m0_r <= method_r;
    end
  end

  // stage 1: table lookup, min/max, channel sum, small weight products
  logic [CH_W-1:0] mx0, mn0, ch0;
  always_comb begin
    mx0 = r0_r;
    mn0 = r0_r;
    if (g0_r > mx0) mx0 = g0_r;
    if (b0_r > mx0) mx0 = b0_r;
    if (g0_r < mn0) mn0 = g0_r;
    if (b0_r < mn0) mn0 = b0_r;
    unique case (m0_r)
      METH_RED:   ch0 = r0_r;
      METH_GREEN: ch0 = g0_r;
      METH_BLUE:  ch0 = b0_r;
      default:    ch0 = mx0;
    endcase
  end

  logic [G_W-1:0]  gr1_r, gg1_r, gb1_r;
  logic [CH_W-1:0] mx1_r, mn1_r, ch1_r;
  logic [CH_W+1:0] s1_r;
  logic [PW-1:0]   pr1_r, pg1_r, pb1_r;
  gray_mode_t m1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      gr1_r <= g_tab[r0_r];
      gg1_r <= g_tab[g0_r];
      gb1_r <= g_tab[b0_r];
      mx1_r <= mx0;
      mn1_r <= mn0;
      ch1_r <= ch0;
      s1_r  <= (CH_W+2)'(r0_r) + (CH_W+2)'(g0_r) + (CH_W+2)'(b0_r);
      pr1_r <= PW'(WR) * PW'(r0_r);
      pg1_r <= PW'(WG) * PW'(g0_r);
      pb1_r <= PW'(WB) * PW'(b0_r);
      m1_r  <= m0_r;
    end
  end

  // stage 2: linear-light weight products, mean reciprocal, weighted sum
  logic [YW-1:0]   yr2_r, yg2_r, yb2_r;
  logic [SW-1:0]   ws2_r;
  logic [MW-1:0]   mean2_r;
  logic [CH_W-1:0] diff2_r, mx2_r, ch2_r;
  gray_mode_t m2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      yr2_r   <= YW'(WR) * YW'(gr1_r);
      yg2_r   <= YW'(WG) * YW'(gg1_r);
      yb2_r   <= YW'(WB) * YW'(gb1_r);
      ws2_r   <= SW'(pr1_r) + SW'(pg1_r) + SW'(pb1_r);
      mean2_r <= MW'(s1_r) * MW'(MEAN_MUL);
      diff2_r <= mx1_r - mn1_r;
      mx2_r   <= mx1_r;
      ch2_r   <= ch1_r;
      m2_r    <= m1_r;
    end
  end

  // stage 3: linear sum, divider numerator, direct-method result
  logic [SW-FRAC_BITS-1:0] wsh2;
  logic [CH_W-1:0]         simple2;
  assign wsh2 = ws2_r[SW-1:FRAC_BITS];
  always_comb begin
    unique case (m2_r)
      METH_MEAN:     simple2 = mean2_r[MEAN_SHIFT +: CH_W];
      METH_WEIGHTED: simple2 = (wsh2 > (SW-FRAC_BITS)'(255)) ? 8'd255 : wsh2[CH_W-1:0];
      default:       simple2 = ch2_r;
    endcase
  end

  logic [YW-1:0]     y_r   [STEPS+1];
  logic [CH_W-1:0]   lo_r  [STEPS+1];
  logic [2*CH_W-1:0] rem_r [STEPS+1];
  logic [CH_W-1:0]   quo_r [STEPS+1];
  logic [CH_W-1:0]   mx_r  [STEPS+1];
  logic [CH_W-1:0]   smp_r [STEPS+1];
  gray_mode_t        md_r  [STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      y_r[0]   <= yr2_r + yg2_r + yb2_r;
      lo_r[0]  <= '0;
      rem_r[0] <= (2*CH_W)'(diff2_r) * (2*CH_W)'(255);
      quo_r[0] <= '0;
      mx_r[0]  <= mx2_r;
      smp_r[0] <= simple2;
      md_r[0]  <= m2_r;
    end
  end

  // step stages: one search bit and one quotient bit each
  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam int unsigned BIT = STEPS - 1 - s;
    logic [CH_W-1:0]   cand;
    logic [2*CH_W-1:0] dsh;
    logic              take;
    assign cand = lo_r[s] | CH_W'(1 << BIT);
    assign dsh  = (2*CH_W)'(mx_r[s]) << BIT;
    assign take = dsh <= rem_r[s];

    always_ff @(posedge clk) begin
      if (en) begin
        lo_r[s+1]  <= (gw_tab[cand] <= y_r[s]) ? cand : lo_r[s];
        rem_r[s+1] <= take ? rem_r[s] - dsh : rem_r[s];
        quo_r[s+1] <= take ? quo_r[s] | CH_W'(1 << BIT) : quo_r[s];
        y_r[s+1]   <= y_r[s];
        mx_r[s+1]  <= mx_r[s];
        smp_r[s+1] <= smp_r[s];
        md_r[s+1]  <= md_r[s];
      end
    end
  end

  // output register
  logic [CH_W-1:0] res;
  logic [CH_W-1:0] out_r;
  always_comb begin
    unique case (md_r[STEPS])
      METH_SRGB: res = lo_r[STEPS];
      METH_SAT:  res = (mx_r[STEPS] == '0) ? '0 : quo_r[STEPS];
      default:   res = smp_r[STEPS];
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stream test of the multi-method rgb to gray converter
// ----------------------------------------------------------------------------
// Drives pixels through the input stream under each conversion method, with
// random idle and stall phases and a long output hold-off. A scoreboard
// computes the expected gray level for each accepted pixel and checks every
// output transaction in order.
class gray_scoreboard;
  logic [7:0] gray_q[$];
  logic [2:0] mode;
  int         errors;
  longint unsigned lut[256];
  longint unsigned wr, wg, wb, wsum;

  function new();
    longint unsigned lo, hi, mid, p;
    mode   = 3'd2;
    errors = 0;
    wr   = (2126 * 65536 + 5000) / 10000;
    wg   = (7152 * 65536 + 5000) / 10000;
    wb   = (722 * 65536 + 5000) / 10000;
    wsum = wr + wg + wb;
    for (int i = 0; i < 256; i++) begin
      lo = 0;
      hi = 2048;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        p   = mid * mid * mid * mid * mid;
        if (p * 255 <= (longint'(i) << 55)) lo = mid;
        else hi = mid - 1;
      end
      lut[i] = longint'(i) * i * lo;
    end
  endfunction

  // expected gray level for one pixel
  function logic [7:0] convert(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    longint unsigned mx, mn, y, res, lo, hi, mid;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    case (rgbgray_pkg::gray_mode_t'(mode))
      rgbgray_pkg::METH_MEAN:     res = (longint'(r) + g + b) / 3;
      rgbgray_pkg::METH_WEIGHTED: begin
        res = (wr * r + wg * g + wb * b) >> 16;
        if (res > 255) res = 255;
      end
      rgbgray_pkg::METH_SRGB: begin
        y = wr * lut[r] + wg * lut[g] + wb * lut[b];
        lo = 0;
        hi = 255;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          if (lut[mid] * wsum <= y) lo = mid;
          else hi = mid - 1;
        end
        res = lo;
      end
      rgbgray_pkg::METH_RED:   res = r;
      rgbgray_pkg::METH_GREEN: res = g;
      rgbgray_pkg::METH_BLUE:  res = b;
      rgbgray_pkg::METH_SAT:   res = (mx == 0) ? 0 : (255 * (mx - mn)) / mx;
      default:                 res = mx;
    endcase
    return res[7:0];
  endfunction

  function void note_pixel(logic [23:0] pix);
    gray_q.push_back(convert(pix[7:0], pix[15:8], pix[23:16]));
  endfunction

  function void check_gray(logic [7:0] got);
    logic [7:0] exp_gray;
    if (gray_q.size() == 0) begin
      $display("%0t: unexpected gray, expected none, actual %0d", $time, got);
      errors++;
      return;
    end
    exp_gray = gray_q.pop_front();
    if (got !== exp_gray) begin
      $display("%0t: gray mismatch, expected %0d, actual %0d", $time, exp_gray, got);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import rgbgray_pkg::*;

  localparam int LATENCY = 13;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;    // red [7:0], green [15:8], blue [23:16]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // gray [7:0]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  gray_scoreboard sb = new();
  int send_idle;      // percent idle on the input side
  int recv_stall;     // percent stall on the output side
  bit hold_off;
  bit done;

  rgb_to_gray_multi_method dut (.*);

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // input transaction monitor
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_pixel(in_tdata);
  end

  // output transaction check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_gray(out_tdata);
  end

  // receiver ready, random stall or long hold-off
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall);
  end

  // long receiver hold-off in its own process
  task automatic hold_receiver(int cycles);
    hold_off = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off = 1'b0;
  endtask

  // register write, setup then access
  task automatic write_mode(gray_mode_t m);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'd0;
    cfg_pwdata  <= {$urandom_range(1) ? 29'h1fffffff : 29'h0, m};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.mode = m;
  endtask

  // send one pixel, optional idle cycles before it
  task automatic send_pixel(logic [23:0] pix);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.gray_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_pixel();
    case ($urandom_range(5))
      0: return {8'($urandom_range(1) * 255), 8'($urandom_range(1) * 255),
                 8'($urandom_range(1) * 255)};
      1: return {3{8'($urandom)}};
      2: return {$urandom_range(7) == 0 ? 8'd0 : 8'($urandom),
                 8'($urandom_range(15)), 8'($urandom)};
      default: return 24'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    gray_mode_t m;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    send_idle   = 0;
    recv_stall  = 0;
    hold_off    = 1'b0;
    done        = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset mode first, then each method with corner pixels
    send_pixel(24'hffffff);
    send_pixel(24'h000000);
    send_pixel(24'h0000ff);
    drain();
    for (int k = 0; k < 8; k++) begin
      m = gray_mode_t'(k);
      write_mode(m);
      send_pixel(24'h000000);
      send_pixel(24'hffffff);
      send_pixel(24'h00ff00);
      send_pixel(24'h808080);
      send_pixel(24'h01ff7f);
      drain();
    end

    // random phases over modes and idle patterns
    for (int ph = 0; ph < 16; ph++) begin
      m = gray_mode_t'(ph % 8);
      write_mode(m);
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 67; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 67; end
        default: begin send_idle = 8; recv_stall = 8; end
      endcase
      if (ph == 5) begin
        fork
          hold_receiver(200);
        join_none
      end
      for (int n = 0; n < 68; n++) begin
        send_pixel(rand_pixel());
        if (n == 34 && ph == 3) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (sb.gray_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    done = 1'b1;
  end

  // end of run
  initial begin
    wait (done);
    if (sb.errors == 0 && sb.gray_q.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end
endmodule

>>> sim.f
rtl/core/rgbgray_pkg.sv
rtl/core/rgb_to_gray_multi_method.sv
sim/tb_top.sv
